>>> src/srps_pkg.sv
// Shared types and codes of the short-term reference picture set decoder.
package srps_pkg;

   // Syntax element kinds carried by the mode field.
   localparam logic [1:0] MODE_BEGIN_DIRECT = 2'd0;
   localparam logic [1:0] MODE_DIRECT_ENTRY = 2'd1;
   localparam logic [1:0] MODE_BEGIN_INTER  = 2'd2;
   localparam logic [1:0] MODE_INTER_FLAGS  = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ERROR     = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   // Slots reserved per set in the entry table.
   localparam int SLOTS = 16;

   // One stored entry: delta POC and its used-by-current flag.
   typedef struct packed {
      logic        used;
      logic [15:0] delta;
   } entry_type;

   // Write strobes towards the table memories.
   typedef struct packed {
      logic counts_we;
      logic entry_we;
   } tbl_ctrl_type;

endpackage

>>> src/srps_tables.sv
// Table memories: per-set entry counts and per-set delta POC entries.
module srps_tables #(
   parameter int MAX_SETS = 64
) (
   input  logic                         clock,
   input  srps_pkg::tbl_ctrl_type       ctrl,
   input  logic [$clog2(MAX_SETS+1)-1:0] counts_waddr,
   input  logic [9:0]                   counts_wdata,
   input  logic [$clog2(MAX_SETS+1)-1:0] counts_raddr,
   output logic [9:0]                   counts_rdata,
   input  logic [$clog2(MAX_SETS+1)+3:0] entry_waddr,
   input  srps_pkg::entry_type          entry_wdata,
   input  logic [$clog2(MAX_SETS+1)+3:0] entry_raddr,
   output srps_pkg::entry_type          entry_rdata
);
   import srps_pkg::*;

   localparam int SET_DEPTH   = MAX_SETS + 1;
   localparam int ENTRY_DEPTH = SET_DEPTH * SLOTS;

   logic [9:0] counts_mem [0:SET_DEPTH-1];
   entry_type  entry_mem  [0:ENTRY_DEPTH-1];
   logic [9:0] counts_rdata_ff;
   entry_type  entry_rdata_ff;

   // Count table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.counts_we) begin
         counts_mem[counts_waddr] <= counts_wdata;
      end
      counts_rdata_ff <= counts_mem[counts_raddr];
   end

   // Entry table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      entry_rdata_ff <= entry_mem[entry_raddr];
   end

   assign counts_rdata = counts_rdata_ff;
   assign entry_rdata  = entry_rdata_ff;

endmodule

>>> src/short_term_rps_decoder.sv
// Top level of the short-term reference picture set decoder.
//
// Usage. Decoded syntax elements arrive on the req_ ports and are taken at a
// rising edge with start high and busy low. Every result appears on the rsp_
// ports for exactly one cycle, marked by rsp_strobe; rsp_last flags the final
// result of an item. The receiver cannot stall, so results are never held.
// The set count register is written through csr_we and csr_wdata; write it
// only while the block is idle, as the block itself does not enforce this.
// Sequencing. Begin and direct entry items give their result (if any) in the
// cycle after the transfer and busy stays low, so one item per cycle.
// A begin inter item holds busy while the reference set's counts are read
// from the count memory. The final inter flag item walks the reference set
// twice through the entry memory, one entry per cycle, then emits one result
// per cycle while writing the new set back.
// Reset clears the control state and the set count; the tables are not
// cleared and hold no valid data until sets are decoded into them.
module short_term_rps_decoder #(
   parameter int MAX_SETS   = 64,
   parameter int MAX_DELTAS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_set_index,
   input  logic [4:0]  req_count_negative,
   input  logic [4:0]  req_count_positive,
   input  logic [14:0] req_delta_minus1,
   input  logic [5:0]  req_ref_distance_minus1,
   input  logic        req_delta_sign,
   input  logic        req_used_flag,
   input  logic        req_use_delta,
   output logic        rsp_strobe,
   output logic        rsp_has_entry,
   output logic        rsp_list_positive,
   output logic [3:0]  rsp_entry_index,
   output logic signed [15:0] rsp_delta_poc,
   output logic        rsp_used_by_current,
   output logic [4:0]  rsp_num_negative,
   output logic [4:0]  rsp_num_positive,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import srps_pkg::*;

   localparam int SET_W = $clog2(MAX_SETS + 1);
   localparam int CAP   = (MAX_DELTAS < SLOTS) ? MAX_DELTAS : SLOTS;
   localparam logic [4:0] CAP_L      = 5'(CAP);
   localparam logic [6:0] MAX_SET_ID = 7'(MAX_SETS);
   localparam int CAND_DEPTH = SLOTS + 1;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_LOADREF = 5'b00010,
      ST_WALK    = 5'b00100,
      ST_FINISH  = 5'b01000,
      ST_EMIT    = 5'b10000
   } ctrl_state_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_DIRECT = 3'b010,
      PH_INTER  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [15:0] delta;
      logic        used;
      logic        sat;
   } cand_type;

   ctrl_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [6:0]        set_count_ff, set_count_in;
   logic [6:0]        current_set_ff, current_set_in;
   logic [4:0]        position_ff, position_in;
   logic signed [15:0] running_ff, running_in;
   logic [6:0]        reference_ff, reference_in;
   logic signed [16:0] delta_rps_ff, delta_rps_in;
   logic [4:0]        cur_nn_ff, cur_nn_in, cur_np_ff, cur_np_in;
   logic [4:0]        ref_nn_ff, ref_nn_in, ref_np_ff, ref_np_in;
   logic [1:0]        flag_ff [0:CAND_DEPTH-1];
   logic              flag_we;
   logic [4:0]        flag_waddr;
   logic [1:0]        flag_wdata;
   logic              walk_sel_ff, walk_sel_in;
   logic [5:0]        step_ff, step_in;
   logic              p_valid_ff, p_valid_in;
   logic              p_rps_ff, p_rps_in;
   logic [1:0]        p_flag_ff, p_flag_in;
   cand_type          cand0_ff [0:CAND_DEPTH-1];
   cand_type          cand1_ff [0:CAND_DEPTH-1];
   logic              cand_we;
   cand_type          cand_wdata;
   logic [4:0]        n0_ff, n0_in, n1_ff, n1_in;
   logic [4:0]        nn_ff, nn_in, np_ff, np_in;
   logic              ov_ff, ov_in;
   logic [4:0]        emit_ff, emit_in;

   logic              strobe_ff, strobe_in;
   logic              has_ff, has_in;
   logic              lst_ff, lst_in;
   logic [3:0]        idx_ff, idx_in;
   logic [15:0]       dpoc_ff, dpoc_in;
   logic              used_ff, used_in;
   logic [4:0]        onn_ff, onn_in, onp_ff, onp_in;
   logic [1:0]        stat_ff, stat_in;
   logic              last_ff, last_in;

   tbl_ctrl_type      tbl_ctrl;
   logic [SET_W-1:0]  counts_waddr, counts_raddr;
   logic [9:0]        counts_wdata, counts_rdata;
   logic [SET_W+3:0]  entry_waddr, entry_raddr;
   entry_type         entry_wdata, entry_rdata;

   // Working values of the combinational step.
   logic [15:0]        dp1;
   logic [5:0]         cnt_sum;
   logic signed [7:0]  ref_calc;
   logic signed [17:0] run_base, run_sum;
   logic               run_neg;
   logic [5:0]         lim;
   logic [5:0]         first_cnt, base_first, base_second, slot;
   logic               issue_rps;
   logic signed [17:0] walk_sum;
   logic               walk_keep;
   logic [4:0]         fin_nn, fin_np, fin_rem;
   logic               fin_ov;
   logic [5:0]         emit_total;
   logic               emit_s1;
   logic [4:0]         emit_k;
   cand_type           emit_c;

   srps_tables #(
      .MAX_SETS(MAX_SETS)
   ) u_tables (
      .clock        (clock),
      .ctrl         (tbl_ctrl),
      .counts_waddr (counts_waddr),
      .counts_wdata (counts_wdata),
      .counts_raddr (counts_raddr),
      .counts_rdata (counts_rdata),
      .entry_waddr  (entry_waddr),
      .entry_wdata  (entry_wdata),
      .entry_raddr  (entry_raddr),
      .entry_rdata  (entry_rdata)
   );

   assign busy = (state_ff != ST_IDLE);

   // Next state, table accesses and the result of the cycle.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      set_count_in   = csr_we ? csr_wdata : set_count_ff;
      current_set_in = current_set_ff;
      position_in    = position_ff;
      running_in     = running_ff;
      reference_in   = reference_ff;
      delta_rps_in   = delta_rps_ff;
      cur_nn_in      = cur_nn_ff;
      cur_np_in      = cur_np_ff;
      ref_nn_in      = ref_nn_ff;
      ref_np_in      = ref_np_ff;
      walk_sel_in    = walk_sel_ff;
      step_in        = step_ff;
      p_valid_in     = 1'b0;
      p_rps_in       = p_rps_ff;
      p_flag_in      = p_flag_ff;
      n0_in          = n0_ff;
      n1_in          = n1_ff;
      nn_in          = nn_ff;
      np_in          = np_ff;
      ov_in          = ov_ff;
      emit_in        = emit_ff;
      flag_we        = 1'b0;
      flag_waddr     = position_ff;
      flag_wdata     = {req_use_delta | req_used_flag, req_used_flag};
      cand_we        = 1'b0;
      cand_wdata     = '0;

      tbl_ctrl       = '0;
      counts_waddr   = req_set_index[SET_W-1:0];
      counts_wdata   = {req_count_positive, req_count_negative};
      counts_raddr   = '0;
      entry_waddr    = {current_set_ff[SET_W-1:0], position_ff[3:0]};
      entry_wdata    = '0;
      entry_raddr    = '0;

      strobe_in = 1'b0;
      has_in    = 1'b0;
      lst_in    = 1'b0;
      idx_in    = '0;
      dpoc_in   = '0;
      used_in   = 1'b0;
      onn_in    = '0;
      onp_in    = '0;
      stat_in   = STATUS_OK;
      last_in   = 1'b1;

      dp1      = {1'b0, req_delta_minus1} + 16'd1;
      cnt_sum  = {1'b0, req_count_negative} + {1'b0, req_count_positive};
      ref_calc = $signed({1'b0, req_set_index}) - 8'sd1
                 - ((req_set_index == set_count_ff) ?
                    $signed({2'b00, req_ref_distance_minus1}) : 8'sd0);
      run_neg  = (position_ff < cur_nn_ff);
      run_base = (!run_neg && position_ff == cur_nn_ff) ? 18'sd0 : 18'(running_ff);
      run_sum  = run_neg ? run_base - $signed({2'b00, dp1})
                         : run_base + $signed({2'b00, dp1});

      lim         = {1'b0, ref_nn_ff} + {1'b0, ref_np_ff};
      first_cnt   = walk_sel_ff ? {1'b0, ref_nn_ff} : {1'b0, ref_np_ff};
      base_first  = walk_sel_ff ? 6'd0 : {1'b0, ref_nn_ff};
      base_second = walk_sel_ff ? {1'b0, ref_nn_ff} : 6'd0;
      issue_rps   = (step_ff == first_cnt);
      if (step_ff < first_cnt) begin
         slot = base_first + first_cnt - 6'd1 - step_ff;
      end else begin
         slot = base_second + step_ff - first_cnt - 6'd1;
      end
      walk_sum = p_rps_ff ? 18'(delta_rps_ff)
                          : 18'($signed(entry_rdata.delta)) + 18'(delta_rps_ff);
      walk_keep = p_flag_ff[1] && (walk_sel_ff ? (walk_sum > 18'sd0) : (walk_sum < 18'sd0));

      fin_nn  = (n0_ff > CAP_L) ? CAP_L : n0_ff;
      fin_rem = CAP_L - fin_nn;
      fin_np  = (n1_ff > fin_rem) ? fin_rem : n1_ff;
      fin_ov  = (fin_nn < n0_ff) || (fin_np < n1_ff);
      for (int k = 0; k < CAND_DEPTH; k++) begin
         if ((5'(k) < fin_nn && cand0_ff[k].sat) || (5'(k) < fin_np && cand1_ff[k].sat)) begin
            fin_ov = 1'b1;
         end
      end

      emit_total = {1'b0, nn_ff} + {1'b0, np_ff};
      emit_s1    = (emit_ff >= nn_ff);
      emit_k     = emit_s1 ? emit_ff - nn_ff : emit_ff;
      emit_c     = emit_s1 ? cand1_ff[emit_k] : cand0_ff[emit_k];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               stat_in   = STATUS_ERROR;
               case (req_mode)
                  MODE_BEGIN_DIRECT: begin
                     phase_in = PH_IDLE;
                     if (!(req_set_index > set_count_ff || req_set_index > MAX_SET_ID
                           || cnt_sum > {1'b0, CAP_L})) begin
                        tbl_ctrl.counts_we = 1'b1;
                        current_set_in = req_set_index;
                        position_in    = '0;
                        running_in     = '0;
                        cur_nn_in      = req_count_negative;
                        cur_np_in      = req_count_positive;
                        stat_in        = STATUS_OK;
                        if (cnt_sum != 6'd0) begin
                           phase_in  = PH_DIRECT;
                           strobe_in = 1'b0;
                        end
                     end
                  end
                  MODE_DIRECT_ENTRY: begin
                     if (phase_ff != PH_DIRECT || req_set_index != current_set_ff) begin
                        phase_in = PH_IDLE;
                     end else begin
                        stat_in = STATUS_OK;
                        if (run_sum > 18'sd32767) begin
                           running_in = 16'sh7fff;
                           stat_in    = STATUS_SATURATED;
                        end else if (run_sum < -18'sd32768) begin
                           running_in = 16'sh8000;
                           stat_in    = STATUS_SATURATED;
                        end else begin
                           running_in = run_sum[15:0];
                        end
                        tbl_ctrl.entry_we = 1'b1;
                        entry_wdata  = '{used: req_used_flag, delta: running_in};
                        position_in  = position_ff + 5'd1;
                        if ({1'b0, position_in} >= {1'b0, cur_nn_ff} + {1'b0, cur_np_ff}) begin
                           phase_in = PH_IDLE;
                        end
                        has_in  = 1'b1;
                        lst_in  = !run_neg;
                        idx_in  = run_neg ? position_ff[3:0] : 4'(position_ff - cur_nn_ff);
                        dpoc_in = running_in;
                        used_in = req_used_flag;
                        onn_in  = cur_nn_ff;
                        onp_in  = cur_np_ff;
                     end
                  end
                  MODE_BEGIN_INTER: begin
                     phase_in = PH_IDLE;
                     if (!(req_set_index == 7'd0 || req_set_index > set_count_ff
                           || req_set_index > MAX_SET_ID || ref_calc < 8'sd0)) begin
                        current_set_in = req_set_index;
                        reference_in   = ref_calc[6:0];
                        delta_rps_in   = req_delta_sign ? -$signed({1'b0, dp1})
                                                        : $signed({1'b0, dp1});
                        position_in    = '0;
                        phase_in       = PH_INTER;
                        counts_raddr   = ref_calc[SET_W-1:0];
                        strobe_in      = 1'b0;
                        state_in       = ST_LOADREF;
                     end
                  end
                  default: begin
                     if (phase_ff != PH_INTER || req_set_index != current_set_ff) begin
                        phase_in = PH_IDLE;
                     end else begin
                        strobe_in   = 1'b0;
                        flag_we     = 1'b1;
                        position_in = position_ff + 5'd1;
                        if ({1'b0, position_in} > lim) begin
                           phase_in    = PH_IDLE;
                           state_in    = ST_WALK;
                           walk_sel_in = 1'b0;
                           step_in     = '0;
                           n0_in       = '0;
                           n1_in       = '0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_LOADREF: begin
            // Count memory data for the reference set is here now.
            ref_nn_in = counts_rdata[4:0];
            ref_np_in = counts_rdata[9:5];
            state_in  = ST_IDLE;
         end
         ST_WALK: begin
            // Issue one reference entry read per cycle.
            if (step_ff <= lim) begin
               entry_raddr = {reference_ff[SET_W-1:0], slot[3:0]};
               p_valid_in  = 1'b1;
               p_rps_in    = issue_rps;
               p_flag_in   = flag_ff[issue_rps ? lim[4:0] : slot[4:0]];
               step_in     = step_ff + 6'd1;
            end
            // Process the entry read in the previous cycle.
            if (p_valid_ff && walk_keep) begin
               cand_we = 1'b1;
               cand_wdata.used = p_flag_ff[0];
               cand_wdata.sat  = (walk_sum > 18'sd32767) || (walk_sum < -18'sd32768);
               if (walk_sum > 18'sd32767) begin
                  cand_wdata.delta = 16'h7fff;
               end else if (walk_sum < -18'sd32768) begin
                  cand_wdata.delta = 16'h8000;
               end else begin
                  cand_wdata.delta = walk_sum[15:0];
               end
               if (walk_sel_ff) begin
                  n1_in = n1_ff + 5'd1;
               end else begin
                  n0_in = n0_ff + 5'd1;
               end
            end
            if (step_ff > lim && !p_valid_ff) begin
               if (walk_sel_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  walk_sel_in = 1'b1;
                  step_in     = '0;
               end
            end
         end
         ST_FINISH: begin
            // Trim to capacity, settle the status and store the counts.
            nn_in              = fin_nn;
            np_in              = fin_np;
            ov_in              = fin_ov;
            emit_in            = '0;
            tbl_ctrl.counts_we = 1'b1;
            counts_waddr       = current_set_ff[SET_W-1:0];
            counts_wdata       = {fin_np, fin_nn};
            state_in           = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            stat_in   = ov_ff ? STATUS_SATURATED : STATUS_OK;
            if (emit_total == 6'd0) begin
               state_in = ST_IDLE;
            end else begin
               tbl_ctrl.entry_we = 1'b1;
               entry_waddr = {current_set_ff[SET_W-1:0], emit_ff[3:0]};
               entry_wdata = '{used: emit_c.used, delta: emit_c.delta};
               has_in  = 1'b1;
               lst_in  = emit_s1;
               idx_in  = emit_k[3:0];
               dpoc_in = emit_c.delta;
               used_in = emit_c.used;
               onn_in  = nn_ff;
               onp_in  = np_ff;
               last_in = ({1'b0, emit_ff} + 6'd1 == emit_total);
               emit_in = emit_ff + 5'd1;
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_IDLE;
         set_count_ff   <= '0;
         current_set_ff <= '0;
         position_ff    <= '0;
         running_ff     <= '0;
         reference_ff   <= '0;
         delta_rps_ff   <= '0;
         walk_sel_ff    <= 1'b0;
         step_ff        <= '0;
         p_valid_ff     <= 1'b0;
         n0_ff          <= '0;
         n1_ff          <= '0;
         emit_ff        <= '0;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         set_count_ff   <= set_count_in;
         current_set_ff <= current_set_in;
         position_ff    <= position_in;
         running_ff     <= running_in;
         reference_ff   <= reference_in;
         delta_rps_ff   <= delta_rps_in;
         walk_sel_ff    <= walk_sel_in;
         step_ff        <= step_in;
         p_valid_ff     <= p_valid_in;
         n0_ff          <= n0_in;
         n1_ff          <= n1_in;
         emit_ff        <= emit_in;
         strobe_ff      <= strobe_in;
      end
   end

   // Payload registers, flag buffer and candidate lists.
   always_ff @(posedge clock) begin
      cur_nn_ff <= cur_nn_in;
      cur_np_ff <= cur_np_in;
      ref_nn_ff <= ref_nn_in;
      ref_np_ff <= ref_np_in;
      p_rps_ff  <= p_rps_in;
      p_flag_ff <= p_flag_in;
      nn_ff     <= nn_in;
      np_ff     <= np_in;
      ov_ff     <= ov_in;
      has_ff    <= has_in;
      lst_ff    <= lst_in;
      idx_ff    <= idx_in;
      dpoc_ff   <= dpoc_in;
      used_ff   <= used_in;
      onn_ff    <= onn_in;
      onp_ff    <= onp_in;
      stat_ff   <= stat_in;
      last_ff   <= last_in;
      if (flag_we) begin
         flag_ff[flag_waddr] <= flag_wdata;
      end
      if (cand_we) begin
         if (walk_sel_ff) begin
            cand1_ff[n1_ff] <= cand_wdata;
         end else begin
            cand0_ff[n0_ff] <= cand_wdata;
         end
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_has_entry       = has_ff;
   assign rsp_list_positive   = lst_ff;
   assign rsp_entry_index     = idx_ff;
   assign rsp_delta_poc       = dpoc_ff;
   assign rsp_used_by_current = used_ff;
   assign rsp_num_negative    = onn_ff;
   assign rsp_num_positive    = onp_ff;
   assign rsp_status          = stat_ff;
   assign rsp_last            = last_ff;

endmodule
